>>> src/c2dw_pkg.sv
package c2dw_pkg;

  localparam int MaxRows   = 32;
  localparam int MaxCols   = 32;
  localparam int MaxKernel = 8;

  localparam int RowW   = $clog2(MaxRows);
  localparam int ColW   = $clog2(MaxCols);
  localparam int KIdxW  = $clog2(MaxKernel);
  localparam int ImgAw  = $clog2(MaxRows * MaxCols);
  localparam int KerAw  = $clog2(MaxKernel * MaxKernel);

  localparam int ValW   = 16;
  localparam int ProdW  = 2 * ValW;
  localparam int SumW   = 40;
  localparam int ImgSzW = 6;
  localparam int KerSzW = 4;
  localparam int CfgW   = 6;
  localparam int CfgAw  = 2;
  localparam int PosW   = 6;

  typedef enum logic [1:0] {
    CMD_PIXEL  = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_SUM    = 2'd2,
    CMD_NOP    = 2'd3
  } c2dw_cmd_e;

  typedef enum logic [CfgAw-1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_KERNEL_ROWS = 2'd2,
    REG_KERNEL_COLS = 2'd3
  } c2dw_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } c2dw_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } c2dw_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic kernel_empty;
    logic tap_last;
    logic pipe_busy;
  } c2dw_stat_t;

endpackage

>>> src/c2dw_ctrl.sv
module c2dw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  c2dw_pkg::c2dw_stat_t stat_i,
  output c2dw_pkg::c2dw_ctl_t  ctl_o
);

  c2dw_pkg::c2dw_state_e st_q, st_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o  = (st_q == c2dw_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= c2dw_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    st_d           = st_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    ctl_o.start    = 1'b0;
    ctl_o.step     = 1'b0;
    ctl_o.load_out = 1'b0;
    unique case (st_q)
      c2dw_pkg::S_IDLE: begin
        if (accept) begin
          ctl_o.start = 1'b1;
          if (cmd_i == c2dw_pkg::CMD_SUM) begin
            st_d = stat_i.kernel_empty ? c2dw_pkg::S_DRAIN : c2dw_pkg::S_RUN;
          end else begin
            st_d = c2dw_pkg::S_DONE;
          end
        end
      end
      c2dw_pkg::S_RUN: begin
        ctl_o.step = 1'b1;
        if (stat_i.tap_last) begin
          st_d = c2dw_pkg::S_DRAIN;
        end
      end
      c2dw_pkg::S_DRAIN: begin
        // wait until the last product has landed in the accumulator
        if (!stat_i.pipe_busy) begin
          st_d = c2dw_pkg::S_DONE;
        end
      end
      c2dw_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          st_d           = c2dw_pkg::S_IDLE;
        end
      end
      default: st_d = c2dw_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (st_q != c2dw_pkg::S_IDLE))
    else $error("accepted request did not start work");

  a_last_tap_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == c2dw_pkg::S_RUN && stat_i.tap_last) |=> (st_q == c2dw_pkg::S_DRAIN))
    else $error("last tap not followed by drain");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  a_no_step_outside_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.step |-> (st_q == c2dw_pkg::S_RUN))
    else $error("tap issued outside run state");
`endif

endmodule

>>> src/c2dw_dp.sv
module c2dw_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [c2dw_pkg::CfgAw-1:0]          cfg_addr_i,
  input  logic [c2dw_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic [1:0]                          cmd_i,
  input  logic [4:0]                          row_i,
  input  logic [4:0]                          col_i,
  input  logic signed [c2dw_pkg::ValW-1:0]    value_i,
  input  logic signed [c2dw_pkg::PosW-1:0]    start_row_i,
  input  logic signed [c2dw_pkg::PosW-1:0]    start_col_i,
  input  c2dw_pkg::c2dw_ctl_t                 ctl_i,
  output c2dw_pkg::c2dw_stat_t                stat_o,
  output logic signed [c2dw_pkg::SumW-1:0]    window_sum_o,
  output logic                                status_o
);

  localparam int IW = c2dw_pkg::ImgSzW;
  localparam int KW = c2dw_pkg::KerSzW;
  localparam int XW = c2dw_pkg::KIdxW;

  // configuration registers
  logic [IW-1:0] img_rows_q, img_cols_q;
  logic [KW-1:0] ker_rows_q, ker_cols_q;
  logic [IW-1:0] ir, ic;
  logic [KW-1:0] kr, kc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_rows_q <= IW'(28);
      img_cols_q <= IW'(28);
      ker_rows_q <= KW'(3);
      ker_cols_q <= KW'(3);
    end else if (cfg_we_i) begin
      unique case (c2dw_pkg::c2dw_reg_e'(cfg_addr_i))
        c2dw_pkg::REG_IMAGE_ROWS:  img_rows_q <= cfg_wdata_i;
        c2dw_pkg::REG_IMAGE_COLS:  img_cols_q <= cfg_wdata_i;
        c2dw_pkg::REG_KERNEL_ROWS: ker_rows_q <= cfg_wdata_i[KW-1:0];
        c2dw_pkg::REG_KERNEL_COLS: ker_cols_q <= cfg_wdata_i[KW-1:0];
        default: ;
      endcase
    end
  end

  // sizes in use saturate at the store dimensions
  assign ir = (img_rows_q > IW'(c2dw_pkg::MaxRows))   ? IW'(c2dw_pkg::MaxRows)   : img_rows_q;
  assign ic = (img_cols_q > IW'(c2dw_pkg::MaxCols))   ? IW'(c2dw_pkg::MaxCols)   : img_cols_q;
  assign kr = (ker_rows_q > KW'(c2dw_pkg::MaxKernel)) ? KW'(c2dw_pkg::MaxKernel) : ker_rows_q;
  assign kc = (ker_cols_q > KW'(c2dw_pkg::MaxKernel)) ? KW'(c2dw_pkg::MaxKernel) : ker_cols_q;

  // write decode
  logic img_ok, ker_ok, img_we, ker_we, bad_wr;
  logic [c2dw_pkg::ImgAw-1:0] img_waddr, img_raddr;
  logic [c2dw_pkg::KerAw-1:0] ker_waddr, ker_raddr;

  assign img_ok = ({1'b0, row_i} < ir) && ({1'b0, col_i} < ic);
  assign ker_ok = (row_i < 5'(kr)) && (col_i < 5'(kc));
  assign img_we = ctl_i.start && (cmd_i == c2dw_pkg::CMD_PIXEL) && img_ok;
  assign ker_we = ctl_i.start && (cmd_i == c2dw_pkg::CMD_WEIGHT) && ker_ok;
  assign bad_wr = ((cmd_i == c2dw_pkg::CMD_PIXEL) && !img_ok)
               || ((cmd_i == c2dw_pkg::CMD_WEIGHT) && !ker_ok);
  assign img_waddr = c2dw_pkg::ImgAw'(32'(row_i[c2dw_pkg::RowW-1:0]) * c2dw_pkg::MaxCols
                                      + 32'(col_i[c2dw_pkg::ColW-1:0]));
  assign ker_waddr = c2dw_pkg::KerAw'(32'(row_i[XW-1:0]) * c2dw_pkg::MaxKernel
                                      + 32'(col_i[XW-1:0]));

  // window origin and tap counters
  logic signed [c2dw_pkg::PosW-1:0] sr_q, sc_q;
  logic [XW-1:0] ki_q, kj_q;
  logic          stat_q;
  logic          col_last, row_last;

  assign col_last = ({1'b0, kj_q} == kc - KW'(1));
  assign row_last = ({1'b0, ki_q} == kr - KW'(1));

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sr_q   <= start_row_i;
      sc_q   <= start_col_i;
      ki_q   <= '0;
      kj_q   <= '0;
      stat_q <= bad_wr;
    end else if (ctl_i.step) begin
      if (col_last) begin
        kj_q <= '0;
        ki_q <= ki_q + XW'(1);
      end else begin
        kj_q <= kj_q + XW'(1);
      end
    end
  end

  // image position under the current tap
  logic signed [c2dw_pkg::PosW:0] pr, pc;
  logic tap_in;

  assign pr = {sr_q[c2dw_pkg::PosW-1], sr_q} + $signed((c2dw_pkg::PosW+1)'(ki_q));
  assign pc = {sc_q[c2dw_pkg::PosW-1], sc_q} + $signed((c2dw_pkg::PosW+1)'(kj_q));
  assign tap_in = !pr[c2dw_pkg::PosW] && (pr[c2dw_pkg::PosW-1:0] < ir)
               && !pc[c2dw_pkg::PosW] && (pc[c2dw_pkg::PosW-1:0] < ic);
  assign img_raddr = c2dw_pkg::ImgAw'(32'(pr[c2dw_pkg::RowW-1:0]) * c2dw_pkg::MaxCols
                                      + 32'(pc[c2dw_pkg::ColW-1:0]));
  assign ker_raddr = c2dw_pkg::KerAw'(32'(ki_q) * c2dw_pkg::MaxKernel + 32'(kj_q));

  // stores
  logic [c2dw_pkg::ValW-1:0] img_mem [c2dw_pkg::MaxRows * c2dw_pkg::MaxCols];
  logic [c2dw_pkg::ValW-1:0] ker_mem [c2dw_pkg::MaxKernel * c2dw_pkg::MaxKernel];
  logic signed [c2dw_pkg::ValW-1:0] pix_q, wgt_q;

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[img_waddr] <= value_i;
    end
    pix_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ker_we) begin
      ker_mem[ker_waddr] <= value_i;
    end
    wgt_q <= ker_mem[ker_raddr];
  end

  // read, multiply, accumulate
  logic v1_q, v2_q;
  logic signed [c2dw_pkg::ProdW-1:0] prod_q;
  logic signed [c2dw_pkg::SumW-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.step && tap_in;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pix_q * wgt_q;
    if (ctl_i.start) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + c2dw_pkg::SumW'(prod_q);
    end
    if (ctl_i.load_out) begin
      window_sum_o <= acc_q;
      status_o     <= stat_q;
    end
  end

  assign stat_o.kernel_empty = (kr == '0) || (kc == '0);
  assign stat_o.tap_last     = col_last && row_last;
  assign stat_o.pipe_busy    = v1_q || v2_q;

endmodule

>>> src/conv2d_window_zero_pad.sv
// 2d convolution window with zero padding over a 32x32 image store and an 8x8
// kernel store of signed q8.8 values. cmd 0 writes a pixel, cmd 1 writes a
// weight (out-of-range coordinates are dropped with status 1), cmd 2 sums
// weight times pixel over every kernel tap that lands inside the image, giving
// an exact signed q24.16 result. One request is in work at a time; a finished
// result waits in an output register and the next request may be taken on the
// cycle after it is loaded there, before it is read. Writes and no-ops pass
// through the done state to the output register; a window sum is worked by
// the single multiply-accumulate unit stepping through the taps one per cycle
// behind a registered store read and a registered product, plus the drain of
// that pipeline, and an empty kernel goes straight to the drain. A result
// still waiting in the output register holds back the next load. Sizes above
// the store dimensions saturate; a zero size gives an empty window and rejects
// writes.
module conv2d_window_zero_pad (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [c2dw_pkg::CfgAw-1:0]          cfg_addr_i,
  input  logic [c2dw_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [4:0]                          row_i,
  input  logic [4:0]                          col_i,
  input  logic signed [c2dw_pkg::ValW-1:0]    value_i,
  input  logic signed [c2dw_pkg::PosW-1:0]    start_row_i,
  input  logic signed [c2dw_pkg::PosW-1:0]    start_col_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [c2dw_pkg::SumW-1:0]    window_sum_o,
  output logic                                status_o
);

  c2dw_pkg::c2dw_ctl_t  ctl;
  c2dw_pkg::c2dw_stat_t stat;

  c2dw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  c2dw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .start_row_i  (start_row_i),
    .start_col_i  (start_col_i),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .window_sum_o (window_sum_o),
    .status_o     (status_o)
  );

endmodule

>>> test/tb_conv2d_window_zero_pad.sv
module tb_conv2d_window_zero_pad;
  timeunit 1ns;
  timeprecision 1ps;

  import c2dw_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 100;
  localparam int ItemTarget    = 540;
  localparam int QuietTail     = 440;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic                   status;
  } window_result_t;

  class window_scoreboard;
    logic signed [ValW-1:0] pixels [MaxRows*MaxCols];
    logic signed [ValW-1:0] weights [MaxKernel*MaxKernel];
    bit                     pixel_written [MaxRows*MaxCols];
    bit                     weight_written [MaxKernel*MaxKernel];
    logic [ImgSzW-1:0]      image_rows;
    logic [ImgSzW-1:0]      image_cols;
    logic [KerSzW-1:0]      kernel_rows;
    logic [KerSzW-1:0]      kernel_cols;
    window_result_t         expected_q [$];
    int                     errors;

    function new();
      image_rows  = 28;
      image_cols  = 28;
      kernel_rows = 3;
      kernel_cols = 3;
      errors      = 0;
      foreach (pixel_written[k]) pixel_written[k] = 1'b0;
      foreach (weight_written[k]) weight_written[k] = 1'b0;
    endfunction

    // sizes above the store dimensions saturate
    function int rows_in_use();
      return (image_rows > MaxRows) ? MaxRows : int'(image_rows);
    endfunction

    function int cols_in_use();
      return (image_cols > MaxCols) ? MaxCols : int'(image_cols);
    endfunction

    function int krows_in_use();
      return (kernel_rows > MaxKernel) ? MaxKernel : int'(kernel_rows);
    endfunction

    function int kcols_in_use();
      return (kernel_cols > MaxKernel) ? MaxKernel : int'(kernel_cols);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_config(c2dw_reg_e idx, logic [CfgW-1:0] data);
      case (idx)
        REG_IMAGE_ROWS:  image_rows  = data[ImgSzW-1:0];
        REG_IMAGE_COLS:  image_cols  = data[ImgSzW-1:0];
        REG_KERNEL_ROWS: kernel_rows = data[KerSzW-1:0];
        REG_KERNEL_COLS: kernel_cols = data[KerSzW-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(c2dw_cmd_e op, logic [4:0] row, logic [4:0] col,
                               logic signed [ValW-1:0] value,
                               logic signed [PosW-1:0] sr, logic signed [PosW-1:0] sc);
      window_result_t exp;
      int ir, ic, kr, kc, pr, pc, i, j;
      longint acc;
      ir  = rows_in_use();
      ic  = cols_in_use();
      kr  = krows_in_use();
      kc  = kcols_in_use();
      acc = 0;
      exp.status = 1'b0;
      case (op)
        CMD_PIXEL: begin
          if (int'(row) < ir && int'(col) < ic) begin
            pixels[row*MaxCols+col]        = value;
            pixel_written[row*MaxCols+col] = 1'b1;
          end else begin
            exp.status = 1'b1;
          end
        end
        CMD_WEIGHT: begin
          if (int'(row) < kr && int'(col) < kc) begin
            weights[row*MaxKernel+col]        = value;
            weight_written[row*MaxKernel+col] = 1'b1;
          end else begin
            exp.status = 1'b1;
          end
        end
        CMD_SUM: begin
          for (i = 0; i < kr; i++) begin
            pr = int'(sr) + i;
            if (pr < 0 || pr >= ir) continue;
            for (j = 0; j < kc; j++) begin
              pc = int'(sc) + j;
              if (pc < 0 || pc >= ic) continue;
              acc += longint'(weights[i*MaxKernel+j]) * longint'(pixels[pr*MaxCols+pc]);
            end
          end
        end
        default: ;
      endcase
      exp.sum = acc[SumW-1:0];
      expected_q.insert(expected_q.size(), exp);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic signed [SumW-1:0] got_sum, logic got_status);
      window_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing outstanding: sum %0d status %0b",
                         got_sum, got_status));
        return;
      end
      exp = expected_q.pop_front();
      if (got_sum !== exp.sum)
        report($sformatf("window_sum %0d, want %0d", got_sum, exp.sum));
      if (got_status !== exp.status)
        report($sformatf("status %0b, want %0b", got_status, exp.status));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CfgAw-1:0]       cfg_addr   = '0;
  logic [CfgW-1:0]        cfg_wdata  = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [1:0]             cmd        = '0;
  logic [4:0]             row        = '0;
  logic [4:0]             col        = '0;
  logic signed [ValW-1:0] value      = '0;
  logic signed [PosW-1:0] start_row  = '0;
  logic signed [PosW-1:0] start_col  = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic signed [SumW-1:0] window_sum;
  logic                   status;

  window_scoreboard sb = new();
  bit idling_on = 1'b1;
  int items_sent = 0;
  int stall_left = 0;

  conv2d_window_zero_pad DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .row_i        (row),
    .col_i        (col),
    .value_i      (value),
    .start_row_i  (start_row),
    .start_col_i  (start_col),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .window_sum_o (window_sum),
    .status_o     (status)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: check accepted results, stall in short bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) sb.check_result(window_sum, status);
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && !((in_valid && in_ready) || (out_valid && out_ready))) quiet++;
      else quiet = 0;
      if (quiet >= WatchdogLimit) break;
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_image_size();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return MaxRows;
      2: return $urandom_range(33, 63);
      3: return $urandom_range(11, 31);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  function automatic int pick_kernel_size();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return MaxKernel;
      2: return $urandom_range(9, 15);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic send_request(c2dw_cmd_e op, logic [4:0] r, logic [4:0] c,
                              logic [ValW-1:0] v,
                              logic signed [PosW-1:0] sr, logic signed [PosW-1:0] sc);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    row       <= r;
    col       <= c;
    value     <= v;
    start_row <= sr;
    start_col <= sc;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(op, r, c, v, sr, sc);
    items_sent++;
  endtask

  // a window sum may only touch written entries, so fill any gaps first
  task automatic send_sum(logic signed [PosW-1:0] sr, logic signed [PosW-1:0] sc);
    int ir, ic, kr, kc, pr, pc, i, j;
    ir = sb.rows_in_use();
    ic = sb.cols_in_use();
    kr = sb.krows_in_use();
    kc = sb.kcols_in_use();
    for (i = 0; i < kr; i++) begin
      pr = int'(sr) + i;
      if (pr < 0 || pr >= ir) continue;
      for (j = 0; j < kc; j++) begin
        pc = int'(sc) + j;
        if (pc < 0 || pc >= ic) continue;
        if (!sb.weight_written[i*MaxKernel+j])
          send_request(CMD_WEIGHT, 5'(i), 5'(j), pick_value(), PosW'($urandom),
                       PosW'($urandom));
        if (!sb.pixel_written[pr*MaxCols+pc])
          send_request(CMD_PIXEL, 5'(pr), 5'(pc), pick_value(), PosW'($urandom),
                       PosW'($urandom));
      end
    end
    send_request(CMD_SUM, 5'($urandom), 5'($urandom), 16'($urandom), sr, sc);
  endtask

  task automatic write_reg(c2dw_reg_e idx, logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.note_config(idx, data);
  endtask

  // sizes change only once every outstanding result has come back
  task automatic configure(int ir, int ic, int kr, int kc);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
    write_reg(REG_IMAGE_ROWS, CfgW'(ir));
    write_reg(REG_IMAGE_COLS, CfgW'(ic));
    // upper data bits are unused by the kernel size registers
    write_reg(REG_KERNEL_ROWS, {2'($urandom), 4'(kr)});
    write_reg(REG_KERNEL_COLS, {2'($urandom), 4'(kc)});
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int ir, ic, kr, kc, pick;
    logic [4:0] r, c;
    logic signed [PosW-1:0] sr, sc;
    c2dw_cmd_e op;
    ir   = sb.rows_in_use();
    ic   = sb.cols_in_use();
    kr   = sb.krows_in_use();
    kc   = sb.kcols_in_use();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      sr = PosW'(int'($urandom_range(0, ir + kr)) - kr);
      sc = PosW'(int'($urandom_range(0, ic + kc)) - kc);
      send_sum(sr, sc);
    end else if (pick < 55) begin
      send_sum(PosW'($urandom), PosW'($urandom));
    end else if (pick < 72) begin
      r = (ir == 0 || $urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, ir - 1));
      c = (ic == 0 || $urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, ic - 1));
      send_request(CMD_PIXEL, r, c, pick_value(), PosW'($urandom), PosW'($urandom));
    end else if (pick < 87) begin
      r = (kr == 0 || $urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, kr - 1));
      c = (kc == 0 || $urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, kc - 1));
      send_request(CMD_WEIGHT, r, c, pick_value(), PosW'($urandom), PosW'($urandom));
    end else if (pick < 92) begin
      send_request(CMD_NOP, 5'($urandom), 5'($urandom), 16'($urandom), PosW'($urandom),
                   PosW'($urandom));
    end else begin
      op = c2dw_cmd_e'(2'($urandom));
      if (op == CMD_SUM) send_sum(PosW'($urandom), PosW'($urandom));
      else send_request(op, 5'($urandom), 5'($urandom), 16'($urandom), PosW'($urandom),
                        PosW'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: 28x28 image, 3x3 kernel
    send_sum(-6'sd32, -6'sd32);
    send_sum(6'sd28, 6'sd0);
    send_sum(6'sd31, 6'sd31);
    send_request(CMD_PIXEL, 5'd28, 5'd5, 16'h1234, 6'sd0, 6'sd0);
    send_request(CMD_PIXEL, 5'd3, 5'd28, 16'h1234, 6'sd0, 6'sd0);
    send_request(CMD_WEIGHT, 5'd3, 5'd0, 16'h5678, 6'sd0, 6'sd0);
    send_request(CMD_WEIGHT, 5'd0, 5'd3, 16'h5678, 6'sd0, 6'sd0);
    send_request(CMD_WEIGHT, 5'd31, 5'd31, 16'hffff, -6'sd1, -6'sd1);
    send_request(CMD_NOP, 5'd31, 5'd31, 16'hffff, -6'sd1, -6'sd1);
    send_request(CMD_WEIGHT, 5'd0, 5'd0, 16'h8000, 6'sd0, 6'sd0);
    send_request(CMD_PIXEL, 5'd27, 5'd27, 16'h8000, 6'sd0, 6'sd0);
    // only tap (0,0) lands inside the image here
    send_sum(6'sd27, 6'sd27);
    send_request(CMD_WEIGHT, 5'd0, 5'd0, 16'h7fff, 6'sd0, 6'sd0);
    send_sum(6'sd27, 6'sd27);

    // empty dimensions reject writes and give an empty window
    configure(0, MaxCols, 0, MaxKernel);
    send_request(CMD_PIXEL, 5'd0, 5'd0, 16'h0001, 6'sd0, 6'sd0);
    send_request(CMD_WEIGHT, 5'd0, 5'd0, 16'h0001, 6'sd0, 6'sd0);
    send_sum(6'sd0, 6'sd0);

    // oversized registers saturate to the store dimensions
    configure(63, 40, 15, 9);
    send_request(CMD_PIXEL, 5'd31, 5'd31, 16'h7fff, 6'sd0, 6'sd0);
    send_request(CMD_WEIGHT, 5'd7, 5'd7, 16'h8000, 6'sd0, 6'sd0);
    send_request(CMD_WEIGHT, 5'd8, 5'd0, 16'h8000, 6'sd0, 6'sd0);
    send_sum(6'sd31, 6'sd31);

    configure(1, 1, 1, 1);
    send_request(CMD_PIXEL, 5'd0, 5'd0, 16'hffff, 6'sd0, 6'sd0);
    send_sum(6'sd0, 6'sd0);
    send_sum(-6'sd1, 6'sd0);

    while (items_sent < ItemTarget) begin
      idling_on = (items_sent < QuietTail) && ($urandom_range(0, 3) != 0);
      configure(pick_image_size(), pick_image_size(), pick_kernel_size(), pick_kernel_size());
      repeat (30) begin
        if (items_sent < ItemTarget) random_request();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
